FILE: src/gfa_pkg.sv
// Shared types, constants and reduction functions for the Goldilocks field ALU.
// Has no dependencies; every other file of the block imports it.
package gfa_pkg;

  localparam int unsigned OpW        = 3;
  localparam int unsigned WordW      = 64;
  localparam int unsigned HalfW      = WordW / 2;
  localparam int unsigned InFieldsW  = OpW + 2 * WordW;
  localparam int unsigned InTdataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = WordW + 1;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // p = 2^64 - 2^32 + 1 and eps = 2^32 - 1, so that 2^64 = eps mod p.
  localparam logic [WordW-1:0] FieldP   = 64'hFFFF_FFFF_0000_0001;
  localparam logic [WordW-1:0] FieldEps = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_EQ  = 3'd3,
    OP_LT  = 3'd4
  } gfa_op_e;

  typedef struct packed {
    logic [WordW-1:0] p11;
    logic [WordW-1:0] p10;
    logic [WordW-1:0] p01;
    logic [WordW-1:0] p00;
  } gfa_pp_t;

  function automatic logic [WordW-1:0] red64(input logic [WordW-1:0] x);
    return (x >= FieldP) ? (x - FieldP) : x;
  endfunction

  // Reduces hi * 2^64 + lo, using 2^64 = eps and 2^96 = -1 modulo p.
  function automatic logic [WordW-1:0] red128(input logic [WordW-1:0] hi,
                                              input logic [WordW-1:0] lo);
    logic [HalfW-1:0] hh;
    logic [HalfW-1:0] hl;
    logic [WordW-1:0] t0;
    logic [WordW-1:0] t1;
    logic [WordW:0]   sum;
    logic [WordW-1:0] t2;
    hh  = hi[WordW-1:HalfW];
    hl  = hi[HalfW-1:0];
    t0  = lo - {{HalfW{1'b0}}, hh};
    if (lo < {{HalfW{1'b0}}, hh}) begin
      t0 = t0 - FieldEps;
    end
    t1  = {hl, {HalfW{1'b0}}} - {{HalfW{1'b0}}, hl};
    sum = {1'b0, t0} + {1'b0, t1};
    t2  = sum[WordW-1:0];
    if (sum[WordW]) begin
      t2 = t2 + FieldEps;
    end
    return red64(t2);
  endfunction

endpackage

FILE: src/gfa_pp.sv
// Registered 32 x 32 partial products of the 64-bit field multiplier.
// Depends on gfa_pkg for the word widths and the product bundle type.
module gfa_pp (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [gfa_pkg::WordW-1:0]  a_i,
  input  logic [gfa_pkg::WordW-1:0]  b_i,
  output gfa_pkg::gfa_pp_t           pp_o
);
  import gfa_pkg::*;

  gfa_pp_t pp_d;
  gfa_pp_t pp_q;

  always_comb begin
    pp_d.p00 = {{HalfW{1'b0}}, a_i[HalfW-1:0]} * {{HalfW{1'b0}}, b_i[HalfW-1:0]};
    pp_d.p01 = {{HalfW{1'b0}}, a_i[HalfW-1:0]} * {{HalfW{1'b0}}, b_i[WordW-1:HalfW]};
    pp_d.p10 = {{HalfW{1'b0}}, a_i[WordW-1:HalfW]} * {{HalfW{1'b0}}, b_i[HalfW-1:0]};
    pp_d.p11 = {{HalfW{1'b0}}, a_i[WordW-1:HalfW]} * {{HalfW{1'b0}}, b_i[WordW-1:HalfW]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
    end
  end

  assign pp_o = pp_q;

endmodule

FILE: src/gfa_alu.sv
// Add, subtract, equality and less-than datapath of the Goldilocks field ALU.
// Depends on gfa_pkg for the opcodes and the reduction functions.
module gfa_alu (
  input  gfa_pkg::gfa_op_e           op_i,
  input  logic [gfa_pkg::WordW-1:0]  a_i,
  input  logic [gfa_pkg::WordW-1:0]  b_i,
  output logic [gfa_pkg::WordW-1:0]  value_o,
  output logic                       flag_o
);
  import gfa_pkg::*;

  logic [WordW:0]   sum;
  logic [WordW-1:0] ra;
  logic [WordW-1:0] rb;

  assign sum = {1'b0, a_i} + {1'b0, b_i};
  assign ra  = red64(a_i);
  assign rb  = red64(b_i);

  always_comb begin
    value_o = '0;
    flag_o  = 1'b0;
    case (op_i)
      OP_ADD: value_o = red128({{(WordW-1){1'b0}}, sum[WordW]}, sum[WordW-1:0]);
      OP_SUB: value_o = (ra >= rb) ? (ra - rb) : (ra + (FieldP - rb));
      OP_EQ:  flag_o  = (ra == rb);
      OP_LT:  flag_o  = (a_i < b_i);
      default: begin
        value_o = '0;
        flag_o  = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/gfa_mred.sv
// Combines the four partial products into a 128-bit product and reduces it mod p.
// Depends on gfa_pkg for the product bundle type and red128.
module gfa_mred (
  input  gfa_pkg::gfa_pp_t           pp_i,
  output logic [gfa_pkg::WordW-1:0]  value_o
);
  import gfa_pkg::*;

  logic [HalfW+1:0] mid;
  logic [WordW-1:0] lo;
  logic [WordW-1:0] hi;

  assign mid = {2'b00, pp_i.p00[WordW-1:HalfW]} + {2'b00, pp_i.p01[HalfW-1:0]}
             + {2'b00, pp_i.p10[HalfW-1:0]};
  assign lo  = {mid[HalfW-1:0], pp_i.p00[HalfW-1:0]};
  assign hi  = pp_i.p11 + {{HalfW{1'b0}}, pp_i.p01[WordW-1:HalfW]}
             + {{HalfW{1'b0}}, pp_i.p10[WordW-1:HalfW]}
             + {{(WordW-2){1'b0}}, mid[HalfW+1:HalfW]};
  assign value_o = red128(hi, lo);

endmodule

FILE: src/goldilocks_field_alu.sv
// Top level of the Goldilocks field ALU: a three-register pipeline of operations mod p.
// Depends on gfa_pkg, gfa_pp, gfa_alu and gfa_mred.
//
// One operation enters on the slave stream and one result leaves on the master
// stream for each transfer. An input tdata carries the opcode, operand_a and
// operand_b; an output tdata carries field_value and compare_flag. Opcodes are
// add, subtract and multiply mod p = 2^64 - 2^32 + 1 on any 64-bit operands,
// equality after reduction mod p, and raw unsigned less-than; the unused
// opcodes give a zero result.
// An accepted item passes an input register, a register of 32 x 32 partial
// products and the output register before its result is offered. The
// multiplier's partial-product register sets the depth; one item is taken in
// every cycle until a stall at the output has filled every stage.
// When the receiver stalls, the result holds in the output register and the
// earlier stages keep filling until every stage holds an item; then
// s_axis_tready_o drops. Reset empties all stages and leaves the block ready.
module goldilocks_field_alu (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // opcode [2:0], operand_a [66:3], operand_b [130:67], zero padding above.
  input  logic [gfa_pkg::InTdataW-1:0]    s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // field_value [63:0], compare_flag [64], zero padding above.
  output logic [gfa_pkg::OutTdataW-1:0]   m_axis_tdata_o
);
  import gfa_pkg::*;

  logic             v1_q, v2_q, v3_q;
  logic             rdy1, rdy2, rdy3;
  gfa_op_e          op1_q, op2_q;
  logic [WordW-1:0] a1_q, b1_q;
  logic [WordW-1:0] val2_d, val2_q;
  logic             flag2_d, flag2_q;
  gfa_pp_t          pp2;
  logic [WordW-1:0] mval;
  logic [WordW-1:0] val3_d, val3_q;
  logic             flag3_q;

  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      op1_q <= gfa_op_e'(s_axis_tdata_i[OpW-1:0]);
      a1_q  <= s_axis_tdata_i[OpW+WordW-1:OpW];
      b1_q  <= s_axis_tdata_i[OpW+2*WordW-1:OpW+WordW];
    end
    if (rdy2) begin
      op2_q   <= op1_q;
      val2_q  <= val2_d;
      flag2_q <= flag2_d;
    end
    if (rdy3) begin
      val3_q  <= val3_d;
      flag3_q <= flag2_q;
    end
  end

  gfa_alu u_alu (
    .op_i    (op1_q),
    .a_i     (a1_q),
    .b_i     (b1_q),
    .value_o (val2_d),
    .flag_o  (flag2_d)
  );

  gfa_pp u_pp (
    .clk_i (clk_i),
    .en_i  (rdy2),
    .a_i   (a1_q),
    .b_i   (b1_q),
    .pp_o  (pp2)
  );

  gfa_mred u_mred (
    .pp_i    (pp2),
    .value_o (mval)
  );

  assign val3_d = (op2_q == OP_MUL) ? mval : val2_q;

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {{(OutTdataW-OutFieldsW){1'b0}}, flag3_q, val3_q};

endmodule

FILE: src/gfa_checker.sv
// Port-level checks of the Goldilocks field ALU, bound to its top level.
// Depends on gfa_pkg for the field prime and the stream widths.
module gfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [gfa_pkg::InTdataW-1:0]   s_axis_tdata_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [gfa_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import gfa_pkg::*;

  // A field result is always fully reduced.
  a_value_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[WordW-1:0] < FieldP))
    else $error("field_value is not reduced below p");

  // A set compare_flag never comes with a nonzero field value.
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[WordW]) |-> (m_axis_tdata_o[WordW-1:0] == '0))
    else $error("compare_flag set together with a nonzero field_value");

  // With no result waiting, the pipeline always has room for a transfer.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready while the output register is empty");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed or was withdrawn");

endmodule

bind goldilocks_field_alu gfa_checker u_gfa_checker (.*);

FILE: test/gfa_result_board_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the Goldilocks field ALU test: predicts each result from an accepted operation.
// Depends on gfa_pkg for the opcodes and the stream widths.
package gfa_result_board_pkg;

  import gfa_pkg::*;

  localparam logic [WordW-1:0]   Modulus     = 64'hFFFF_FFFF_0000_0001;
  localparam logic [2*WordW-1:0] ModulusWide = {64'd0, Modulus};
  localparam int unsigned        ReportLimit = 10;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             flag;
  } field_result_t;

  class gfa_result_board;
    field_result_t expected_results[$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function field_result_t predict_result(logic [OpW-1:0] op, logic [WordW-1:0] a,
                                                  logic [WordW-1:0] b);
      field_result_t    r;
      logic [2*WordW-1:0] wide;
      logic [WordW-1:0] ra;
      logic [WordW-1:0] rb;
      r  = '0;
      ra = a % Modulus;
      rb = b % Modulus;
      case (op)
        OP_ADD: begin
          wide    = {64'd0, a} + {64'd0, b};
          r.value = WordW'(wide % ModulusWide);
        end
        OP_SUB: begin
          wide    = {64'd0, ra} + ModulusWide - {64'd0, rb};
          r.value = WordW'(wide % ModulusWide);
        end
        OP_MUL: begin
          wide    = {64'd0, a} * {64'd0, b};
          r.value = WordW'(wide % ModulusWide);
        end
        OP_EQ:   r.flag = (ra == rb);
        OP_LT:   r.flag = (a < b);
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_operation(logic [OpW-1:0] op, logic [WordW-1:0] a, logic [WordW-1:0] b);
      expected_results.push_back(predict_result(op, a, b));
    endfunction

    function void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("[%0t] %s", $time, what);
      end
    endfunction

    function void check_result(logic [OutTdataW-1:0] tdata);
      field_result_t want;
      logic [WordW-1:0] got_value;
      logic             got_flag;
      got_value = tdata[WordW-1:0];
      got_flag  = tdata[WordW];
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value=%h flag=%b", got_value, got_flag));
        return;
      end
      want = expected_results.pop_front();
      if (got_value !== want.value) begin
        flag_mismatch($sformatf("field_value expected %h actual %h", want.value, got_value));
      end
      if (got_flag !== want.flag) begin
        flag_mismatch($sformatf("compare_flag expected %b actual %b", want.flag, got_flag));
      end
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction
  endclass

endpackage

FILE: test/goldilocks_field_alu_test.sv
`timescale 1ns / 1ps
// Stream test of the Goldilocks field ALU with directed and random operations under idling and receiver stalls.
// Depends on gfa_pkg, gfa_result_board_pkg and the goldilocks_field_alu block.
module goldilocks_field_alu_test;

  import gfa_pkg::*;
  import gfa_result_board_pkg::*;

  localparam logic [OpW-1:0]   OpSpareFirst = 3'd5;
  localparam logic [OpW-1:0]   OpSpareMid   = 3'd6;
  localparam logic [OpW-1:0]   OpSpareLast  = 3'd7;
  localparam logic [WordW-1:0] AllOnes      = '1;
  localparam logic [WordW-1:0] Pow32        = 64'h0000_0001_0000_0000;
  localparam logic [WordW-1:0] Pow48        = 64'h0001_0000_0000_0000;
  localparam int unsigned      PhaseItems   = 175;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  gfa_result_board board;

  goldilocks_field_alu dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o);
    end
  end

  // Called and returns at a falling edge.
  task automatic send_operation(logic [OpW-1:0] op, logic [WordW-1:0] a, logic [WordW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i                      = '0;
    s_axis_tdata_i[OpW-1:0]             = op;
    s_axis_tdata_i[OpW+:WordW]          = a;
    s_axis_tdata_i[OpW+WordW+:WordW]    = b;
    s_axis_tvalid_i                     = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    board.note_operation(op, a, b);
    @(negedge clk_i);
  endtask

  function automatic logic [WordW-1:0] random_operand();
    case ($urandom_range(7))
      0:       return WordW'($urandom_range(15));
      1:       return Modulus - 64'd8 + WordW'($urandom_range(16));
      2:       return AllOnes - WordW'($urandom_range(15));
      3:       return Pow32 - 64'd4 + WordW'($urandom_range(8));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_phase(int unsigned idle_pct, int unsigned stall_pct);
    logic [OpW-1:0]   op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PhaseItems) begin
      op = ($urandom_range(9) == 0) ? OpW'($urandom_range(7)) : OpW'($urandom_range(4));
      a  = random_operand();
      b  = random_operand();
      if (op == OP_EQ && $urandom_range(1)) begin
        if (a < Pow32 - 64'd1 && $urandom_range(1)) begin
          b = a + Modulus;
        end else if (a >= Modulus && $urandom_range(1)) begin
          b = a - Modulus;
        end else begin
          b = a;
        end
      end
      send_operation(op, a, b);
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_operation(OP_ADD, Modulus - 64'd1, 64'd1);
    send_operation(OP_ADD, AllOnes, AllOnes);
    send_operation(OP_ADD, Modulus, Modulus);
    send_operation(OP_ADD, 64'd0, 64'd0);
    send_operation(OP_SUB, 64'd0, 64'd1);
    send_operation(OP_SUB, 64'd0, AllOnes);
    send_operation(OP_SUB, AllOnes, 64'd0);
    send_operation(OP_SUB, Modulus, Modulus - 64'd1);
    send_operation(OP_MUL, Modulus - 64'd1, Modulus - 64'd1);
    send_operation(OP_MUL, AllOnes, AllOnes);
    send_operation(OP_MUL, Pow32, Pow32);
    send_operation(OP_MUL, Pow48, Pow48);
    send_operation(OP_MUL, 64'd0, AllOnes);
    send_operation(OP_EQ, 64'd0, Modulus);
    send_operation(OP_EQ, Modulus + 64'd1, 64'd1);
    send_operation(OP_EQ, AllOnes, Pow32 - 64'd2);
    send_operation(OP_EQ, 64'd5, 64'd6);
    send_operation(OP_LT, 64'd0, AllOnes);
    send_operation(OP_LT, AllOnes, 64'd0);
    send_operation(OP_LT, 64'd7, 64'd7);
    send_operation(OpSpareFirst, AllOnes, AllOnes);
    send_operation(OpSpareMid, AllOnes, Modulus);
    send_operation(OpSpareLast, AllOnes, AllOnes);

    send_random_phase(0, 0);
    send_random_phase(88, 0);
    send_random_phase(0, 88);
    send_random_phase(25, 25);
    s_axis_tvalid_i = 1'b0;

    while (board.outstanding() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
